// ===== rtl/tdpt_pkg.sv =====
// tdpt_pkg: shared types for the trial division prime test
// command and status structs between the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package tdpt_pkg;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture a new number, restart at divisor two
		logic div_start;  // clear the remainder, point at the top bit
		logic div_step;   // one restoring division bit
		logic next_div;   // advance divisor and its square
	} tdpt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic too_small;  // negative, zero or one
		logic sq_over;    // divisor squared exceeds the number
		logic bit_last;   // current division bit is the lowest one
		logic rem_zero;   // remainder of the finished division is zero
	} tdpt_sts_t;

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// trial_division_prime_test: top level of the trial division prime test
// joins tdpt_ctrl and tdpt_dp and holds the result output register
// depends on tdpt_pkg, tdpt_ctrl, tdpt_dp
`timescale 1ns / 1ps

// Tests one signed DATA_WIDTH-bit number per request for primality by trial
// division and returns one bit, 1 for prime. Numbers below two are composite
// and go from acceptance through the square check straight to the result.
// Otherwise divisors run from two upward while the divisor squared does not
// exceed the number; each divisor takes one square check, one pass of the bit
// serial restoring divider over all DATA_WIDTH bits of the number, and one
// remainder test. The divider is the limit: at 32 bits a prime near the top
// of the range takes about 46340 divisors. One number is worked on at a time;
// the next request is taken as soon as the result sits in the output register.
module trial_division_prime_test #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [DATA_WIDTH-1:0] value, zero padded to whole bytes
	input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] is_prime, [7:1] zero
	output logic [7:0]                          m_axis_tdata
);

	tdpt_pkg::tdpt_cmd_t cmd;
	tdpt_pkg::tdpt_sts_t sts;

	logic out_valid_q;
	logic out_prime_q;
	logic out_busy;
	logic res_load;
	logic res_prime;

	assign out_busy = out_valid_q && !m_axis_tready;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_busy (out_busy),
		.res_load (res_load),
		.res_prime(res_prime),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdpt_dp #(
		.W(DATA_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.value (s_axis_tdata[DATA_WIDTH-1:0]),
		.cmd   (cmd),
		.sts   (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_prime_q <= 1'b0;
		end else if (res_load) begin
			out_prime_q <= res_prime;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_prime_q};

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while a number is under test");

	a_result_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> m_axis_tvalid && (m_axis_tdata[0] == $past(res_prime)))
		else $error("finished result not presented");
`endif

endmodule

// ===== rtl/tdpt_dp.sv =====
// tdpt_dp: datapath of the trial division prime test
// number, divisor, running square and a bit serial restoring divider
// depends on tdpt_pkg
`timescale 1ns / 1ps

module tdpt_dp #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [W-1:0]       value,
	input  tdpt_pkg::tdpt_cmd_t cmd,
	output tdpt_pkg::tdpt_sts_t sts
);

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] TopBit = CW'(W - 1);

	logic [W-1:0]   n_q;
	logic [W-1:0]   d_q;
	logic [2*W-1:0] sq_q;
	logic [W-1:0]   rem_q;
	logic [CW-1:0]  cnt_q;

	logic [W:0] shifted;
	logic [W:0] diff;

	// remainder stays below the divisor, so the shifted value is below twice it
	assign shifted = {rem_q, n_q[cnt_q]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			d_q   <= W'(2);
			sq_q  <= (2*W)'(4);
			rem_q <= '0;
			cnt_q <= TopBit;
		end else begin
			if (cmd.load) begin
				n_q   <= value;
				d_q   <= W'(2);
				sq_q  <= (2*W)'(4);
				rem_q <= '0;
			end
			if (cmd.div_start) begin
				rem_q <= '0;
				cnt_q <= TopBit;
			end
			if (cmd.div_step) begin
				rem_q <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.next_div) begin
				// (d+1)^2 = d^2 + 2d + 1
				sq_q <= sq_q + (2*W)'({d_q, 1'b1});
				d_q  <= d_q + W'(1);
			end
		end
	end

	assign sts.too_small = n_q[W-1] || (n_q < W'(2));
	assign sts.sq_over   = sq_q > {{W{1'b0}}, n_q};
	assign sts.bit_last  = (cnt_q == '0);
	assign sts.rem_zero  = (rem_q == '0);

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < d_q)
		else $error("remainder not below divisor");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q == (2*W)'(d_q) * (2*W)'(d_q))
		else $error("running square out of step with divisor");
`endif

endmodule

// ===== rtl/tdpt_ctrl.sv =====
// tdpt_ctrl: controller of the trial division prime test
// sequences load, square check, division bits and divisor advance
// depends on tdpt_pkg
`timescale 1ns / 1ps

module tdpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_busy,
	output logic                res_load,
	output logic                res_prime,
	input  tdpt_pkg::tdpt_sts_t sts,
	output tdpt_pkg::tdpt_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		DIVIDE,
		TEST,
		FINISH
	} state_t;

	state_t state_q;
	logic   verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			verdict_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					if (sts.too_small) begin
						verdict_q <= 1'b0;
						state_q   <= FINISH;
					end else if (sts.sq_over) begin
						verdict_q <= 1'b1;
						state_q   <= FINISH;
					end else begin
						state_q <= DIVIDE;
					end
				end
				DIVIDE: begin
					if (sts.bit_last) begin
						state_q <= TEST;
					end
				end
				TEST: begin
					if (sts.rem_zero) begin
						verdict_q <= 1'b0;
						state_q   <= FINISH;
					end else begin
						state_q <= CHECK;
					end
				end
				FINISH: begin
					if (!out_busy) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == IDLE) && in_valid;
		cmd.div_start = (state_q == CHECK) && !sts.too_small && !sts.sq_over;
		cmd.div_step  = (state_q == DIVIDE);
		cmd.next_div  = (state_q == TEST) && !sts.rem_zero;
	end

	assign in_ready  = (state_q == IDLE);
	assign res_load  = (state_q == FINISH) && !out_busy;
	assign res_prime = verdict_q;

`ifndef SYNTHESIS
	a_no_prime_when_small: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CHECK) && sts.too_small |=> (state_q == FINISH) && !verdict_q)
		else $error("small or negative number not reported as composite");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_busy)
		else $error("result written over a pending one");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for trial_division_prime_test
// streams signed numbers in, checks each prime verdict against its own trial division
// depends on trial_division_prime_test and its submodules
`timescale 1ns / 1ps

module tb_top;

	localparam int DATA_WIDTH = 32;
	localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int RESET_CYCLES = 12;
	localparam int PHASE_ITEMS = 20;
	localparam int NUM_PHASES = 4;
	// a prime just under 2**20 needs about 1024 divisors, each a full division
	localparam int QUIET_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// [31:0] value
	logic [TDATA_W-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [0] is_prime, [7:1] zero
	logic [7:0]          m_axis_tdata;

	logic [DATA_WIDTH-1:0] pending_values[$];
	bit                    expected_verdicts[$];
	int unsigned           send_idle_pct = 0;
	int unsigned           recv_stall_pct = 0;
	bit                    sender_hold = 1'b0;
	int                    failures = 0;
	int                    quiet_cycles = 0;

	// sign and size extremes, tiny numbers, squares of primes, large numbers with small factors
	logic [DATA_WIDTH-1:0] directed_values [0:21] = '{
		32'h8000_0000, 32'hffff_ffff, 32'h8000_0001, 32'h0000_0000,
		32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
		32'h0000_0005, 32'h0000_0009, 32'h0000_0019, 32'h0000_0031,
		32'h0000_0061, 32'h0000_0079, 32'h0000_fff1, 32'h0001_0000,
		32'h000f_88e1, 32'h000f_fffd, 32'h7fff_fffe, 32'h7fff_fffd,
		32'h5555_5555, 32'h2aaa_aaaa
	};

	trial_division_prime_test #(
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit predict_prime(input logic [DATA_WIDTH-1:0] value);
		longint unsigned n;
		longint unsigned divisor;
		n = value;
		if (value[DATA_WIDTH-1] || n < 2)
			return 1'b0;
		divisor = 2;
		// divisor <= n / divisor keeps the square test free of overflow
		while (divisor <= n / divisor) begin
			if (n % divisor == 0)
				return 1'b0;
			divisor++;
		end
		return 1'b1;
	endfunction

	// mostly small numbers so primes stay cheap; big ones are negative or carry small factors
	function automatic logic [DATA_WIDTH-1:0] random_candidate();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(15);
		else if (pick < 55)
			return $urandom_range(65535);
		else if (pick < 65)
			return $urandom_range(1048575);
		else if (pick < 80)
			return $urandom() | 32'h8000_0000;
		else if (pick < 90)
			return $urandom() & 32'h7fff_fffe;
		else
			return $urandom_range(715827882) * 3;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_values.size() != 0 && !sender_hold &&
					$urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_values.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk or negedge arst_n) begin : monitor
		bit verdict;
		bit moved;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			moved = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_verdicts.insert(expected_verdicts.size(),
					predict_prime(s_axis_tdata[DATA_WIDTH-1:0]));
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				if (expected_verdicts.size() == 0) begin
					failures++;
					if (failures <= REPORT_MAX)
						$display("unexpected result 0x%02h with no request pending",
							m_axis_tdata);
				end else begin
					verdict = expected_verdicts.pop_front();
					if (m_axis_tdata !== {7'b0, verdict}) begin
						failures++;
						if (failures <= REPORT_MAX)
							$display("is_prime mismatch: expected 0x%02h, got 0x%02h",
								{7'b0, verdict}, m_axis_tdata);
					end
				end
			end
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned send_pct [0:NUM_PHASES-1] = '{0, 48, 0, 19};
		int unsigned recv_pct [0:NUM_PHASES-1] = '{0, 0, 48, 19};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_values[i])
			pending_values.insert(pending_values.size(), directed_values[i]);
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			repeat (PHASE_ITEMS)
				pending_values.insert(pending_values.size(), random_candidate());
			// halfway through, hold requests back until every verdict is in
			while (pending_values.size() > PHASE_ITEMS / 2)
				@(negedge clk);
			sender_hold = 1'b1;
			while (s_axis_tvalid || expected_verdicts.size() != 0)
				@(negedge clk);
			sender_hold = 1'b0;
			while (pending_values.size() != 0 || s_axis_tvalid)
				@(negedge clk);
		end
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && expected_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
